FILE: sv/ggaim_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ggaim_pkg
// Shared types and constants of the affine grid index map: fixed-point
// formats, datapath widths and configuration register indexes.
// ============================================================================
package ggaim_pkg;

    localparam int ANGLE_FRAC_BITS = 24;
    localparam int SCALE_FRAC_BITS = 12;
    localparam int INDEX_BITS      = 24;

    // field widths
    localparam int LAT_W   = 32;
    localparam int LON_W   = 33;
    localparam int EDGE_W  = 34;
    localparam int SCL_W   = 32;
    localparam int OUT_A_W = 34;
    localparam int CFG_W   = 34;

    // datapath widths
    localparam int DLAT_W  = LAT_W + 1;
    localparam int DLON_W  = LON_W + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int RPROD_W = EDGE_W + INDEX_BITS;
    localparam int LANE_W  = PROD_W + 1;
    localparam int LO_W    = (LANE_W + 1) / 2;
    localparam int HI_W    = LANE_W - LO_W;
    localparam int LOP_W   = LO_W + SCL_W;
    localparam int HIP_W   = HI_W + SCL_W + 1;
    localparam int MUL_W   = LANE_W + SCL_W + 1;
    localparam int SUM_W   = MUL_W + 1;
    localparam int NUM_W   = SUM_W + SCALE_FRAC_BITS;
    localparam int DET_W   = PROD_W;
    localparam int DEN_W   = (DET_W + SCALE_FRAC_BITS > 2 * SCL_W) ?
                             DET_W + SCALE_FRAC_BITS : 2 * SCL_W;
    localparam int DV_W    = DEN_W + 1;
    localparam int NN_W    = NUM_W + 2;
    localparam int REV_BIG = 40;
    localparam int QB      = REV_BIG + 1;
    localparam int DW      = DV_W + QB + 2;
    localparam int VW      = 44;

    localparam int NL = 4;
    localparam int NA = 2;

    typedef enum logic [2:0] {
        CFG_ORIGIN_LAT   = 3'd0,
        CFG_ORIGIN_LON   = 3'd1,
        CFG_ACROSS_LAT   = 3'd2,
        CFG_ACROSS_LON   = 3'd3,
        CFG_DOWN_LAT     = 3'd4,
        CFG_DOWN_LON     = 3'd5,
        CFG_CELLS_ACROSS = 3'd6,
        CFG_CELLS_DOWN   = 3'd7
    } t_cfg_idx;

endpackage

FILE: sv/geo_grid_affine_index_map_top.sv
`timescale 1ns / 1ps
// ============================================================================
// geo_grid_affine_index_map_top
// Affine map between latitude/longitude and grid cell indices over a
// parallelogram, forward by Cramer's rule and reverse by scaled rebuild.
// ============================================================================
// One item is taken on every clock (busy stays low) and each item gives one
// result beat, marked by o_strobe for one cycle; the receiver cannot hold
// results off. The two restoring dividers (col/lat and row/lon) retire one
// of 41 quotient bits per pipeline stage after nine stages of subtract,
// multiply and rounding set-up. Registers are written through i_cfg_we /
// i_cfg_idx / i_cfg_data and must only change while no item is in flight.
module geo_grid_affine_index_map_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_func,
    input  logic signed [ggaim_pkg::LAT_W-1:0]     i_point_lat,
    input  logic signed [ggaim_pkg::LON_W-1:0]     i_point_lon,
    input  logic signed [ggaim_pkg::INDEX_BITS-1:0] i_cell_col,
    input  logic signed [ggaim_pkg::INDEX_BITS-1:0] i_cell_row,
    input  logic                                   i_cfg_we,
    input  ggaim_pkg::t_cfg_idx                    i_cfg_idx,
    input  logic [ggaim_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                   o_strobe,
    output logic signed [ggaim_pkg::INDEX_BITS-1:0] o_out_col,
    output logic signed [ggaim_pkg::INDEX_BITS-1:0] o_out_row,
    output logic signed [ggaim_pkg::OUT_A_W-1:0]   o_out_lat,
    output logic signed [ggaim_pkg::OUT_A_W-1:0]   o_out_lon,
    output logic                                   o_degenerate,
    output logic                                   o_saturated
);
    import ggaim_pkg::*;

    localparam int PRE = 8;
    localparam int LAT = QB + 11;
    localparam logic [QB-1:0] Q_IDX_LIM = QB'(64'd1 << (INDEX_BITS - 1));
    localparam logic [QB-1:0] Q_IDX_MAX = Q_IDX_LIM - QB'(1);
    localparam logic [QB-1:0] Q_BIG     = QB'(64'd1 << REV_BIG);
    localparam logic signed [VW-1:0] ANG_LIM = VW'(64'sd360 <<< ANGLE_FRAC_BITS);
    localparam logic signed [VW-1:0] ANG_MAX = ANG_LIM - VW'(1);
    localparam logic signed [VW-1:0] ANG_MIN = -ANG_LIM;

    // configuration registers
    logic signed [LAT_W-1:0]  r_origin_lat;
    logic signed [LON_W-1:0]  r_origin_lon;
    logic signed [EDGE_W-1:0] r_across_lat;
    logic signed [EDGE_W-1:0] r_across_lon;
    logic signed [EDGE_W-1:0] r_down_lat;
    logic signed [EDGE_W-1:0] r_down_lon;
    logic [SCL_W-1:0]         r_cells_across;
    logic [SCL_W-1:0]         r_cells_down;

    logic             accept;
    logic [PRE-1:0]   r_vld;

    // stage 1
    logic                             r1_fn;
    logic signed [DLAT_W-1:0]         r1_dlat;
    logic signed [DLON_W-1:0]         r1_dlon;
    logic signed [INDEX_BITS-1:0]     r1_col;
    logic signed [INDEX_BITS-1:0]     r1_row;
    // stage 2
    logic                             r2_fn;
    logic signed [PROD_W-1:0]         r2_det_a, r2_det_b;
    logic signed [PROD_W-1:0]         r2_ns_a, r2_ns_b, r2_nt_a, r2_nt_b;
    logic signed [RPROD_W-1:0]        r2_c_lat, r2_r_lat, r2_c_lon, r2_r_lon;
    // stage 3
    logic                             r3_fn;
    logic signed [LANE_W-1:0]         r3_det;
    logic signed [LANE_W-1:0]         r3_v [NL];
    logic [SCL_W-1:0]                 r3_s [NL];
    // stage 4
    logic                             r4_fn, r4_degen, r4_dneg;
    logic [DET_W-1:0]                 r4_dabs;
    logic [2*SCL_W-1:0]               r4_cacd;
    logic [LOP_W-1:0]                 r4_lo [NL];
    logic signed [HIP_W-1:0]          r4_hi [NL];
    // stage 5
    logic                             r5_fn, r5_degen, r5_dneg;
    logic [DEN_W-1:0]                 r5_den;
    logic signed [MUL_W-1:0]          r5_prod [NL];
    // stage 6
    logic                             r6_fn, r6_degen;
    logic [DEN_W-1:0]                 r6_den;
    logic signed [NUM_W-1:0]          r6_n [NA];
    logic [NA-1:0]                    r6_neg;
    logic signed [SUM_W-1:0]          n_sum [NA];
    logic signed [NUM_W-1:0]          n_num [NA];
    // stage 7
    logic                             r7_fn, r7_degen;
    logic [DEN_W-1:0]                 r7_den;
    logic [NUM_W-1:0]                 r7_mag [NA];
    logic [NA-1:0]                    r7_neg;
    // stage 8
    logic                             r8_fn, r8_degen;
    logic [DV_W-1:0]                  r8_dv;
    logic [NN_W-1:0]                  r8_num [NA];
    logic [NA-1:0]                    r8_neg;

    // divider pipeline, index 0 is the set-up stage
    logic [QB:0]                      r_d_vld;
    logic                             r_d_fn    [QB+1];
    logic                             r_d_degen [QB+1];
    logic [DV_W-1:0]                  r_d_dv    [QB+1];
    logic [NA-1:0]                    r_d_neg   [QB+1];
    logic [NA-1:0]                    r_d_ovf   [QB+1];
    logic [DW-1:0]                    r_d_rem   [QB+1][NA];
    logic [QB-1:0]                    r_d_q     [QB+1][NA];

    // post stage
    logic                             r_p_vld, r_p_fn, r_p_degen, r_p_fsat;
    logic [INDEX_BITS-1:0]            r_p_idx [NA];
    logic signed [VW-1:0]             r_p_v   [NA];
    logic [INDEX_BITS-1:0]            n_p_idx [NA];
    logic signed [VW-1:0]             n_p_v   [NA];
    logic                             n_p_fsat;
    logic signed [VW-1:0]             n_o_v   [NA];
    logic [NA-1:0]                    n_o_sat;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_lat   <= '0;
            r_origin_lon   <= '0;
            r_across_lat   <= '0;
            r_across_lon   <= '0;
            r_down_lat     <= '0;
            r_down_lon     <= '0;
            r_cells_across <= '0;
            r_cells_down   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_LAT:   r_origin_lat   <= i_cfg_data[LAT_W-1:0];
                CFG_ORIGIN_LON:   r_origin_lon   <= i_cfg_data[LON_W-1:0];
                CFG_ACROSS_LAT:   r_across_lat   <= i_cfg_data[EDGE_W-1:0];
                CFG_ACROSS_LON:   r_across_lon   <= i_cfg_data[EDGE_W-1:0];
                CFG_DOWN_LAT:     r_down_lat     <= i_cfg_data[EDGE_W-1:0];
                CFG_DOWN_LON:     r_down_lon     <= i_cfg_data[EDGE_W-1:0];
                CFG_CELLS_ACROSS: r_cells_across <= i_cfg_data[SCL_W-1:0];
                CFG_CELLS_DOWN:   r_cells_down   <= i_cfg_data[SCL_W-1:0];
                default:          r_cells_down   <= r_cells_down;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_d_vld[0] <= 1'b0;
            r_p_vld    <= 1'b0;
            o_strobe   <= 1'b0;
        end else begin
            r_vld      <= {r_vld[PRE-2:0], accept};
            r_d_vld[0] <= r_vld[PRE-1];
            r_p_vld    <= r_d_vld[QB];
            o_strobe   <= r_p_vld;
        end
    end

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            n_sum[a] = SUM_W'(r5_prod[a]) + SUM_W'(r5_prod[a+2]);
            n_num[a] = r5_fn ? (NUM_W'(n_sum[a]) <<< SCALE_FRAC_BITS) : NUM_W'(n_sum[a]);
        end
    end

    // front stages
    always_ff @(posedge i_clk) begin
        // point relative to origin
        r1_fn   <= i_func;
        r1_dlat <= DLAT_W'(i_point_lat) - DLAT_W'(r_origin_lat);
        r1_dlon <= DLON_W'(i_point_lon) - DLON_W'(r_origin_lon);
        r1_col  <= i_cell_col;
        r1_row  <= i_cell_row;

        // cross products
        r2_fn    <= r1_fn;
        r2_det_a <= r_across_lon * r_down_lat;
        r2_det_b <= r_down_lon * r_across_lat;
        r2_ns_a  <= r_down_lat * r1_dlon;
        r2_ns_b  <= r_down_lon * r1_dlat;
        r2_nt_a  <= r_across_lon * r1_dlat;
        r2_nt_b  <= r_across_lat * r1_dlon;
        r2_c_lat <= r_across_lat * r1_col;
        r2_r_lat <= r_down_lat * r1_row;
        r2_c_lon <= r_across_lon * r1_col;
        r2_r_lon <= r_down_lon * r1_row;

        // lanes: value times scale
        r3_fn  <= r2_fn;
        r3_det <= LANE_W'(r2_det_a) - LANE_W'(r2_det_b);
        if (r2_fn) begin
            r3_v[0] <= LANE_W'(r2_c_lat);
            r3_v[1] <= LANE_W'(r2_c_lon);
            r3_v[2] <= LANE_W'(r2_r_lat);
            r3_v[3] <= LANE_W'(r2_r_lon);
            r3_s[0] <= r_cells_down;
            r3_s[1] <= r_cells_down;
            r3_s[2] <= r_cells_across;
            r3_s[3] <= r_cells_across;
        end else begin
            r3_v[0] <= LANE_W'(r2_ns_a) - LANE_W'(r2_ns_b);
            r3_v[1] <= LANE_W'(r2_nt_a) - LANE_W'(r2_nt_b);
            r3_v[2] <= '0;
            r3_v[3] <= '0;
            r3_s[0] <= r_cells_across;
            r3_s[1] <= r_cells_down;
            r3_s[2] <= '0;
            r3_s[3] <= '0;
        end

        // partial products
        r4_fn    <= r3_fn;
        r4_dneg  <= r3_det[LANE_W-1];
        r4_dabs  <= r3_det[LANE_W-1] ? DET_W'(-r3_det) : DET_W'(r3_det);
        r4_degen <= r3_fn ? (r_cells_across == '0 || r_cells_down == '0)
                          : (r3_det == '0);
        r4_cacd  <= r_cells_across * r_cells_down;
        for (int k = 0; k < NL; k++) begin
            r4_lo[k] <= r3_v[k][LO_W-1:0] * r3_s[k];
            r4_hi[k] <= $signed(r3_v[k][LANE_W-1:LO_W]) * $signed({1'b0, r3_s[k]});
        end

        r5_fn    <= r4_fn;
        r5_degen <= r4_degen;
        r5_dneg  <= r4_dneg;
        r5_den   <= r4_fn ? DEN_W'(r4_cacd) : DEN_W'({r4_dabs, {SCALE_FRAC_BITS{1'b0}}});
        for (int k = 0; k < NL; k++) begin
            r5_prod[k] <= (MUL_W'(r4_hi[k]) <<< LO_W) + MUL_W'(r4_lo[k]);
        end

        // axis sums and result sign
        r6_fn    <= r5_fn;
        r6_degen <= r5_degen;
        r6_den   <= r5_den;
        for (int a = 0; a < NA; a++) begin
            r6_n[a]   <= n_num[a];
            r6_neg[a] <= r5_fn ? n_num[a][NUM_W-1] : (n_num[a][NUM_W-1] ^ r5_dneg);
        end

        r7_fn    <= r6_fn;
        r7_degen <= r6_degen;
        r7_den   <= r6_den;
        r7_neg   <= r6_neg;
        for (int a = 0; a < NA; a++) begin
            r7_mag[a] <= r6_n[a][NUM_W-1] ? NUM_W'(-r6_n[a]) : NUM_W'(r6_n[a]);
        end

        // half away from zero: (2|n| + d) / 2d
        r8_fn    <= r7_fn;
        r8_degen <= r7_degen;
        r8_neg   <= r7_neg;
        r8_dv    <= {r7_den, 1'b0};
        for (int a = 0; a < NA; a++) begin
            r8_num[a] <= NN_W'({r7_mag[a], 1'b0}) + NN_W'(r7_den);
        end

        // quotient range check ahead of the divider
        r_d_fn[0]    <= r8_fn;
        r_d_degen[0] <= r8_degen;
        r_d_neg[0]   <= r8_neg;
        r_d_dv[0]    <= r8_dv;
        for (int a = 0; a < NA; a++) begin
            r_d_rem[0][a] <= DW'(r8_num[a]);
            r_d_q[0][a]   <= '0;
            r_d_ovf[0][a] <= DW'(r8_num[a]) >= (DW'(r8_dv) << QB);
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int SH = QB - 1 - j;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[j+1] <= 1'b0;
            end else begin
                r_d_vld[j+1] <= r_d_vld[j];
            end
            r_d_fn[j+1]    <= r_d_fn[j];
            r_d_degen[j+1] <= r_d_degen[j];
            r_d_neg[j+1]   <= r_d_neg[j];
            r_d_ovf[j+1]   <= r_d_ovf[j];
            r_d_dv[j+1]    <= r_d_dv[j];
            for (int a = 0; a < NA; a++) begin
                if (r_d_rem[j][a] >= (DW'(r_d_dv[j]) << SH)) begin
                    r_d_rem[j+1][a] <= r_d_rem[j][a] - (DW'(r_d_dv[j]) << SH);
                    r_d_q[j+1][a]   <= {r_d_q[j][a][QB-2:0], 1'b1};
                end else begin
                    r_d_rem[j+1][a] <= r_d_rem[j][a];
                    r_d_q[j+1][a]   <= {r_d_q[j][a][QB-2:0], 1'b0};
                end
            end
        end
    end

    // index clamp and angle rebuild
    always_comb begin
        logic [QB-1:0]        q;
        logic [QB-1:0]        qm;
        logic                 neg, ovf, fs, big;
        logic signed [VW-1:0] qs;
        logic signed [VW-1:0] org;
        n_p_fsat = 1'b0;
        for (int a = 0; a < NA; a++) begin
            q   = r_d_q[QB][a];
            neg = r_d_neg[QB][a];
            ovf = r_d_ovf[QB][a];
            fs  = ovf || (neg ? (q > Q_IDX_LIM) : (q > Q_IDX_MAX));
            qm  = fs ? (neg ? Q_IDX_LIM : Q_IDX_MAX) : q;
            n_p_idx[a] = neg ? INDEX_BITS'(-qm) : INDEX_BITS'(qm);
            n_p_fsat   = n_p_fsat || fs;
            big = ovf || (q > Q_BIG);
            qs  = VW'(q);
            org = (a == 0) ? VW'(r_origin_lat) : VW'(r_origin_lon);
            if (big) begin
                n_p_v[a] = neg ? ANG_MIN : ANG_LIM;
            end else begin
                n_p_v[a] = (neg ? -qs : qs) + org;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_fn    <= r_d_fn[QB];
        r_p_degen <= r_d_degen[QB];
        r_p_fsat  <= n_p_fsat;
        r_p_idx   <= n_p_idx;
        r_p_v     <= n_p_v;
    end

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            if (r_p_v[a] < ANG_MIN) begin
                n_o_v[a]   = ANG_MIN;
                n_o_sat[a] = 1'b1;
            end else if (r_p_v[a] > ANG_MAX) begin
                n_o_v[a]   = ANG_MAX;
                n_o_sat[a] = 1'b1;
            end else begin
                n_o_v[a]   = r_p_v[a];
                n_o_sat[a] = 1'b0;
            end
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        o_out_col    <= '0;
        o_out_row    <= '0;
        o_out_lat    <= '0;
        o_out_lon    <= '0;
        o_saturated  <= 1'b0;
        o_degenerate <= r_p_degen;
        if (!r_p_degen) begin
            if (r_p_fn) begin
                o_out_lat   <= n_o_v[0][OUT_A_W-1:0];
                o_out_lon   <= n_o_v[1][OUT_A_W-1:0];
                o_saturated <= |n_o_sat;
            end else begin
                o_out_col   <= r_p_idx[0];
                o_out_row   <= r_p_idx[1];
                o_saturated <= r_p_fsat;
            end
        end
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_strobe)
        else $error("result beat missing after accepted item");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LAT))
        else $error("result beat without an accepted item");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_degenerate |-> !o_saturated && o_out_col == '0 && o_out_row == '0
                                     && o_out_lat == '0 && o_out_lon == '0)
        else $error("degenerate beat carries a result");

    a_one_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_out_lat != '0 || o_out_lon != '0) |-> o_out_col == '0 && o_out_row == '0)
        else $error("both mappings present in one beat");

endmodule
